@@ rtl/core/wps_pkg.sv @@
// ----------------------------------------------------------------------------
// wps_pkg
// shared types, register codes and reset constants of the wake power sequencer
// ----------------------------------------------------------------------------
package wps_pkg;

	// default width of the serial sleep count read from the host
	localparam int COUNT_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// register reset values
	localparam logic [15:0] STARTUP_TICKS_RST      = 16'd3000;
	localparam logic [7:0]  BIT_WAIT_TICKS_RST     = 8'd3;
	localparam logic [15:0] LONG_PRESS_TICKS_RST   = 16'd1000;
	localparam logic [23:0] SLEEP_PERIOD_TICKS_RST = 24'd8000;
	localparam logic [7:0]  DISPLAY_MARGIN_RST     = 8'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STARTUP_TICKS      = 3'd0,
		CFG_BIT_WAIT_TICKS     = 3'd1,
		CFG_LONG_PRESS_TICKS   = 3'd2,
		CFG_SLEEP_PERIOD_TICKS = 3'd3,
		CFG_DISPLAY_MARGIN     = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_STARTUP = 3'd0,
		PH_READY   = 3'd1,
		PH_DONE    = 3'd2,
		PH_READ    = 3'd3,
		PH_DISPLAY = 3'd4,
		PH_SLEEP   = 3'd5,
		PH_PRESS   = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		MODE_NEXT_STEP    = 2'd0,
		MODE_SWITCH_IMAGE = 2'd1,
		MODE_GO_ONLINE    = 2'd3
	} wake_mode_t;

	typedef struct packed {
		logic host_data;
		logic display_busy;
		logic button_pressed;
	} wps_in_t;

	typedef struct packed {
		logic        ldo_enable;
		logic        clock_line;
		logic        mode_high_line;
		logic [1:0]  wake_mode;
		logic [15:0] sleep_count;
		logic [2:0]  phase;
	} wps_out_t;

	typedef struct packed {
		logic [15:0] startup_ticks;
		logic [7:0]  bit_wait_ticks;
		logic [15:0] long_press_ticks;
		logic [23:0] sleep_period_ticks;
		logic [7:0]  display_margin;
	} wps_cfg_t;

endpackage

@@ rtl/core/wake_power_sequencer.sv @@
// ----------------------------------------------------------------------------
// wake_power_sequencer
// wakes a host and a display from long sleep periods and powers them down
// ----------------------------------------------------------------------------
// Each input transaction is one base tick carrying the host data line, the
// display busy line and the button level; each one produces exactly one
// output transaction that shows the sequencer state after that tick. A tick
// is first registered in the input register and its result is then written
// into the result register unless a stalled consumer holds that register, and
// one tick is taken every cycle while the output side keeps up. The whole
// tick update (counters, compares and the saturating count subtract) is one
// combinational step in front of the state registers, which also serve as the
// result register. After reset the regulator is held off for startup_ticks
// ticks. Configuration writes are taken at any time (ready is tied high) but
// must only be issued while no tick is in flight.
// ----------------------------------------------------------------------------
module wake_power_sequencer
	import wps_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// tick input channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  wps_in_t               in_data,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output wps_out_t              out_data,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	wps_cfg_t cfg;

	// input stage
	logic    valid_s1;
	wps_in_t in_s1;

	// result register valid
	logic    out_valid_q;

	logic out_hold;    // result waiting on a stalled consumer
	logic s1_move;     // tick in the input stage is processed this cycle
	logic in_take;     // input transaction accepted this cycle

	assign out_hold = out_valid_q & out_stall;
	assign s1_move  = valid_s1 & ~out_hold;
	// input stage frees up whenever its tick moves on
	assign in_stall = valid_s1 & out_hold;
	assign in_take  = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
			// result stays valid while held, reloads on every processed tick
			out_valid_q <= s1_move | out_hold;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_take) begin
			in_s1 <= in_data;
		end
	end

	wps_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// state registers update only when a tick moves into the result slot
	wps_seq #(
		.COUNT_BITS (COUNT_BITS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (s1_move),
		.tick_in (in_s1),
		.cfg     (cfg),
		.result  (out_data)
	);

	assign out_valid = out_valid_q;

	// a held result must not be overwritten by a new tick
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_hold |-> !s1_move)
		else $error("result overwritten while stalled");

	// a held tick in the input stage blocks new transactions
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_hold) |-> in_stall)
		else $error("input taken over a pending tick");

	// every processed tick shows up as a result on the next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move |=> out_valid_q)
		else $error("processed tick lost its result");

endmodule

@@ rtl/core/wps_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// wps_cfg_regs
// configuration register file, one write transaction per cycle
// ----------------------------------------------------------------------------
module wps_cfg_regs
	import wps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output wps_cfg_t              cfg
);

	wps_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.startup_ticks      <= STARTUP_TICKS_RST;
			cfg_q.bit_wait_ticks     <= BIT_WAIT_TICKS_RST;
			cfg_q.long_press_ticks   <= LONG_PRESS_TICKS_RST;
			cfg_q.sleep_period_ticks <= SLEEP_PERIOD_TICKS_RST;
			cfg_q.display_margin     <= DISPLAY_MARGIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			// unknown indexes are dropped
			case (cfg_index)
				CFG_STARTUP_TICKS:      cfg_q.startup_ticks      <= cfg_data[15:0];
				CFG_BIT_WAIT_TICKS:     cfg_q.bit_wait_ticks     <= cfg_data[7:0];
				CFG_LONG_PRESS_TICKS:   cfg_q.long_press_ticks   <= cfg_data[15:0];
				CFG_SLEEP_PERIOD_TICKS: cfg_q.sleep_period_ticks <= cfg_data;
				CFG_DISPLAY_MARGIN:     cfg_q.display_margin     <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/wps_seq.sv @@
// ----------------------------------------------------------------------------
// wps_seq
// power sequencing state machine, advances one base tick per step
// ----------------------------------------------------------------------------
module wps_seq
	import wps_pkg::*;
#(
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     step,
	input  wps_in_t  tick_in,
	input  wps_cfg_t cfg,
	output wps_out_t result
);

	localparam int BIT_W = $clog2(COUNT_BITS + 1);

	phase_t           phase_q, phase_d;
	logic [23:0]      tick_q, tick_d, tick_inc;
	logic [BIT_W-1:0] bit_cnt_q, bit_cnt_d, bit_inc;
	logic [15:0]      shift_q, shift_d, shift_new;
	logic [15:0]      sleep_q, sleep_d;
	logic [15:0]      period_q, period_d;
	logic [1:0]       mode_q, mode_d, press_mode;
	logic [15:0]      press_q, press_d;
	logic             clk_lvl_q, clk_lvl_d;
	logic             mode_hi_q, mode_hi_d;
	logic             ldo_q, ldo_d;
	logic [16:0]      sub_amt;

	assign tick_inc  = tick_q + 24'd1;
	assign bit_inc   = bit_cnt_q + BIT_W'(1);
	assign shift_new = {shift_q[14:0], tick_in.host_data};
	assign sub_amt   = {1'b0, period_q} + {9'b0, cfg.display_margin};
	assign press_mode = (press_q >= cfg.long_press_ticks) ? MODE_GO_ONLINE : MODE_SWITCH_IMAGE;

	always_comb begin
		phase_d   = phase_q;
		tick_d    = tick_q;
		bit_cnt_d = bit_cnt_q;
		shift_d   = shift_q;
		sleep_d   = sleep_q;
		period_d  = period_q;
		mode_d    = mode_q;
		press_d   = press_q;
		clk_lvl_d = clk_lvl_q;
		mode_hi_d = mode_hi_q;
		ldo_d     = ldo_q;
		unique case (phase_q)
			PH_READY: begin
				if (tick_in.host_data) begin
					mode_hi_d = mode_q[1];
					phase_d   = PH_DONE;
				end
			end
			PH_DONE: begin
				if (!tick_in.host_data) begin
					if (mode_q != MODE_SWITCH_IMAGE) begin
						clk_lvl_d = ~clk_lvl_q;
						tick_d    = '0;
						bit_cnt_d = '0;
						shift_d   = '0;
						phase_d   = PH_READ;
					end else begin
						mode_d  = MODE_NEXT_STEP;
						phase_d = PH_DISPLAY;
					end
				end
			end
			PH_READ: begin
				tick_d = tick_inc;
				if (tick_inc >= {16'b0, cfg.bit_wait_ticks}) begin
					shift_d   = shift_new;
					bit_cnt_d = bit_inc;
					clk_lvl_d = ~clk_lvl_q;
					tick_d    = '0;
					if (bit_inc >= BIT_W'(COUNT_BITS)) begin
						sleep_d   = shift_new;
						mode_d    = MODE_NEXT_STEP;
						bit_cnt_d = '0;
						phase_d   = PH_DISPLAY;
					end
				end
			end
			PH_DISPLAY: begin
				if (!tick_in.display_busy) begin
					ldo_d     = 1'b0;
					clk_lvl_d = 1'b0;
					mode_hi_d = 1'b0;
					period_d  = '0;
					tick_d    = '0;
					phase_d   = PH_SLEEP;
				end
			end
			PH_SLEEP: begin
				if (period_q >= sleep_q) begin
					ldo_d     = 1'b1;
					clk_lvl_d = mode_q[0];
					mode_hi_d = 1'b0;
					phase_d   = PH_READY;
				end else if (tick_in.button_pressed) begin
					mode_d  = MODE_SWITCH_IMAGE;
					press_d = 16'd1;
					phase_d = PH_PRESS;
				end else if (tick_inc >= cfg.sleep_period_ticks) begin
					tick_d   = '0;
					period_d = period_q + 16'd1;
				end else begin
					tick_d = tick_inc;
				end
			end
			PH_PRESS: begin
				if (tick_in.button_pressed) begin
					if (press_q != 16'hFFFF) begin
						press_d = press_q + 16'd1;
					end
				end else begin
					mode_d    = press_mode;
					sleep_d   = ({1'b0, sleep_q} > sub_amt) ? (sleep_q - sub_amt[15:0]) : '0;
					ldo_d     = 1'b1;
					clk_lvl_d = press_mode[0];
					mode_hi_d = 1'b0;
					phase_d   = PH_READY;
				end
			end
			default: begin
				// startup, also taken by the unused code
				ldo_d = 1'b0;
				if (tick_q >= {8'b0, cfg.startup_ticks}) begin
					tick_d    = '0;
					ldo_d     = 1'b1;
					clk_lvl_d = mode_q[0];
					mode_hi_d = 1'b0;
					phase_d   = PH_READY;
				end else begin
					tick_d = tick_inc;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_STARTUP;
			tick_q    <= '0;
			bit_cnt_q <= '0;
			shift_q   <= '0;
			sleep_q   <= '0;
			period_q  <= '0;
			mode_q    <= MODE_NEXT_STEP;
			press_q   <= '0;
			clk_lvl_q <= 1'b0;
			mode_hi_q <= 1'b0;
			ldo_q     <= 1'b0;
		end else if (step) begin
			phase_q   <= phase_d;
			tick_q    <= tick_d;
			bit_cnt_q <= bit_cnt_d;
			shift_q   <= shift_d;
			sleep_q   <= sleep_d;
			period_q  <= period_d;
			mode_q    <= mode_d;
			press_q   <= press_d;
			clk_lvl_q <= clk_lvl_d;
			mode_hi_q <= mode_hi_d;
			ldo_q     <= ldo_d;
		end
	end

	assign result.ldo_enable     = ldo_q;
	assign result.clock_line     = clk_lvl_q;
	assign result.mode_high_line = mode_hi_q;
	assign result.wake_mode      = mode_q;
	assign result.sleep_count    = sleep_q;
	assign result.phase          = phase_q;

	// regulator stays off while asleep, pressed or starting up
	a_ldo_off: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SLEEP || phase_q == PH_PRESS || phase_q == PH_STARTUP) |-> !ldo_q)
		else $error("regulator on in an off phase");

	// bit counter only counts inside a read
	a_bit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_READ) |-> (bit_cnt_q == '0))
		else $error("bit counter not cleared outside read");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_cnt_q < BIT_W'(COUNT_BITS))
		else $error("bit counter out of range");

	// button release ends the press and powers up
	a_release: assert property (@(posedge clk) disable iff (!arst_n)
		(step && phase_q == PH_PRESS && !tick_in.button_pressed)
		|=> (ldo_q && phase_q == PH_READY && mode_q != MODE_NEXT_STEP))
		else $error("release did not power up");

endmodule

@@ tb/sv/wake_power_sequencer_check.sv @@
// ----------------------------------------------------------------------------
// wake_power_sequencer_check
// predicts the status after every accepted tick and compares it with the block
// ----------------------------------------------------------------------------
module wake_power_sequencer_check
	import wps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  wps_in_t               in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  wps_out_t              out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    mismatches,
	output int                    pending
);
	timeunit 1ns;
	timeprecision 1ps;

	wps_cfg_t    cfg_q;
	phase_t      step_q;
	wake_mode_t  mode_q;
	logic [23:0] tick_q;
	logic [4:0]  bit_q;
	logic [15:0] shift_q;
	logic [15:0] sleep_q;
	logic [15:0] period_q;
	logic [15:0] press_q;
	logic        clk_line_q;
	logic        mode_hi_q;
	logic        ldo_q;

	wps_out_t status_due[$];
	int       bad_count = 0;
	int       due_count = 0;

	assign mismatches = bad_count;
	assign pending    = due_count;

	function automatic void power_up();
		ldo_q      = 1'b1;
		clk_line_q = mode_q[0];
		mode_hi_q  = 1'b0;
		step_q     = PH_READY;
	endfunction

	// one base tick of the sequencer, returns the status after the tick
	function automatic wps_out_t sequence_tick(input wps_in_t lv);
		wps_out_t    res;
		logic [16:0] cut;
		case (step_q)
			PH_READY: begin
				if (lv.host_data) begin
					mode_hi_q = mode_q[1];
					step_q    = PH_DONE;
				end
			end
			PH_DONE: begin
				if (!lv.host_data) begin
					if (mode_q != MODE_SWITCH_IMAGE) begin
						clk_line_q = ~clk_line_q;
						tick_q     = '0;
						bit_q      = '0;
						shift_q    = '0;
						step_q     = PH_READ;
					end else begin
						mode_q = MODE_NEXT_STEP;
						step_q = PH_DISPLAY;
					end
				end
			end
			PH_READ: begin
				tick_q = tick_q + 24'd1;
				if (tick_q >= cfg_q.bit_wait_ticks) begin
					shift_q    = {shift_q[14:0], lv.host_data};
					bit_q      = bit_q + 5'd1;
					clk_line_q = ~clk_line_q;
					tick_q     = '0;
					if (bit_q >= COUNT_BITS_DEF) begin
						sleep_q = shift_q;
						mode_q  = MODE_NEXT_STEP;
						bit_q   = '0;
						step_q  = PH_DISPLAY;
					end
				end
			end
			PH_DISPLAY: begin
				if (!lv.display_busy) begin
					ldo_q      = 1'b0;
					clk_line_q = 1'b0;
					mode_hi_q  = 1'b0;
					period_q   = '0;
					tick_q     = '0;
					step_q     = PH_SLEEP;
				end
			end
			PH_SLEEP: begin
				if (period_q >= sleep_q) begin
					power_up();
				end else if (lv.button_pressed) begin
					mode_q  = MODE_SWITCH_IMAGE;
					press_q = 16'd1;
					step_q  = PH_PRESS;
				end else begin
					tick_q = tick_q + 24'd1;
					if (tick_q >= cfg_q.sleep_period_ticks) begin
						tick_q   = '0;
						period_q = period_q + 16'd1;
					end
				end
			end
			PH_PRESS: begin
				if (lv.button_pressed) begin
					if (press_q != 16'hFFFF)
						press_q = press_q + 16'd1;
				end else begin
					cut     = {1'b0, period_q} + cfg_q.display_margin;
					mode_q  = (press_q >= cfg_q.long_press_ticks) ? MODE_GO_ONLINE
						: MODE_SWITCH_IMAGE;
					sleep_q = ({1'b0, sleep_q} > cut) ? sleep_q - cut[15:0] : '0;
					power_up();
				end
			end
			default: begin
				ldo_q = 1'b0;
				if (tick_q >= cfg_q.startup_ticks) begin
					tick_q = '0;
					power_up();
				end else begin
					tick_q = tick_q + 24'd1;
				end
			end
		endcase
		res.ldo_enable     = ldo_q;
		res.clock_line     = clk_line_q;
		res.mode_high_line = mode_hi_q;
		res.wake_mode      = mode_q;
		res.sleep_count    = sleep_q;
		res.phase          = step_q;
		return res;
	endfunction

	function automatic void check_field(input string label, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, label, want, got);
			bad_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		wps_out_t want;
		if (!arst_n) begin
			cfg_q.startup_ticks      = STARTUP_TICKS_RST;
			cfg_q.bit_wait_ticks     = BIT_WAIT_TICKS_RST;
			cfg_q.long_press_ticks   = LONG_PRESS_TICKS_RST;
			cfg_q.sleep_period_ticks = SLEEP_PERIOD_TICKS_RST;
			cfg_q.display_margin     = DISPLAY_MARGIN_RST;
			step_q     = PH_STARTUP;
			mode_q     = MODE_NEXT_STEP;
			tick_q     = '0;
			bit_q      = '0;
			shift_q    = '0;
			sleep_q    = '0;
			period_q   = '0;
			press_q    = '0;
			clk_line_q = 1'b0;
			mode_hi_q  = 1'b0;
			ldo_q      = 1'b0;
			status_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_STARTUP_TICKS:      cfg_q.startup_ticks      = cfg_data[15:0];
					CFG_BIT_WAIT_TICKS:     cfg_q.bit_wait_ticks     = cfg_data[7:0];
					CFG_LONG_PRESS_TICKS:   cfg_q.long_press_ticks   = cfg_data[15:0];
					CFG_SLEEP_PERIOD_TICKS: cfg_q.sleep_period_ticks = cfg_data[23:0];
					CFG_DISPLAY_MARGIN:     cfg_q.display_margin     = cfg_data[7:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (status_due.size() == 0) begin
					$display("%0t: status %h arrived with nothing expected", $time, out_data);
					bad_count++;
				end else begin
					want = status_due.pop_front();
					check_field("ldo_enable", want.ldo_enable, out_data.ldo_enable);
					check_field("clock_line", want.clock_line, out_data.clock_line);
					check_field("mode_high_line", want.mode_high_line, out_data.mode_high_line);
					check_field("wake_mode", want.wake_mode, out_data.wake_mode);
					check_field("sleep_count", want.sleep_count, out_data.sleep_count);
					check_field("phase", want.phase, out_data.phase);
				end
			end
			if (in_valid && !in_stall)
				status_due.push_back(sequence_tick(in_data));
		end
		due_count = status_due.size();
	end

endmodule

@@ tb/sv/wake_power_sequencer_test.sv @@
// ----------------------------------------------------------------------------
// wake_power_sequencer_test
// drives ticks and register settings into the wake power sequencer
// ----------------------------------------------------------------------------
// A short scripted wake cycle comes first, then random ticks shaped by the
// last phase seen on the status channel so that most runs walk the whole
// loop: power on, ready and done handshake, serial count, display wait,
// sleep and button wakes. Each random stretch uses its own register setting
// and its own mix of sender gaps and receiver stalls. The checker beside the
// block predicts every status transaction and counts mismatches.
// ----------------------------------------------------------------------------
module wake_power_sequencer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wps_pkg::*;

	localparam int QUIET_LIMIT = 5000;   // cycles without any transaction
	localparam int HOLD_CYCLES = 200;    // long receiver hold-off
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	wps_in_t               in_data;
	logic                  out_valid;
	logic                  out_stall;
	wps_out_t              out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    mismatches;
	int                    pending;

	// stimulus knobs, set per stretch
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	int unsigned ones_pct      = 10;   // chance of a one per count bit
	int unsigned wake_pct      = 10;   // chance per sleep tick of a button press
	int unsigned press_limit   = 1;    // long press threshold currently written
	int unsigned press_left    = 0;    // remaining ticks of the press in progress
	int unsigned quiet_cycles  = 0;
	bit          hold_req      = 1'b0;
	phase_t      seen_phase;

	wake_power_sequencer u_top (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.in_data,
		.out_valid,
		.out_stall,
		.out_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	wake_power_sequencer_check u_check (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.in_data,
		.out_valid,
		.out_stall,
		.out_data,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data,
		.mismatches,
		.pending
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// last phase reported by the block, used only to shape stimulus
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_phase <= PH_STARTUP;
		else if (out_valid && !out_stall)
			seen_phase <= phase_t'(out_data.phase);
	end

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_stall <= (stall_pct != 0 && $urandom_range(99) < stall_pct);
		end
	end

	// watchdog: any accepted transaction on any channel restarts the count
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("wake_power_sequencer_test NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic wps_in_t levels(input logic host, input logic busy,
		input logic button);
		wps_in_t lv;
		lv.host_data      = host;
		lv.display_busy   = busy;
		lv.button_pressed = button;
		return lv;
	endfunction

	// offer one tick, returns at the edge that accepts it
	task automatic send_tick(input wps_in_t lv);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= lv;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// returns at the edge that accepts the write, valid stays up
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	// all registers written once the block has drained; narrow registers get
	// junk in the upper data bits, and a write to an unused index is mixed in
	task automatic configure(input logic [15:0] startup, input logic [7:0] bit_wait,
		input logic [15:0] long_press, input logic [23:0] period, input logic [7:0] margin);
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		write_reg(CFG_STARTUP_TICKS, {8'($urandom), startup});
		write_reg(CFG_BIT_WAIT_TICKS, {16'($urandom), bit_wait});
		write_reg(CFG_UNUSED, 24'($urandom));
		write_reg(CFG_LONG_PRESS_TICKS, {8'($urandom), long_press});
		write_reg(CFG_SLEEP_PERIOD_TICKS, period);
		write_reg(CFG_DISPLAY_MARGIN, {16'($urandom), margin});
		@(negedge clk);
		cfg_valid <= 1'b0;
		press_limit = long_press;
	endtask

	// pick the next tick: mostly the answer the block waits for, some noise,
	// and button presses around the long press threshold while asleep
	task automatic shape_tick(input bit may_press, output wps_in_t lv);
		int unsigned run;
		lv.host_data      = $urandom_range(1);
		lv.display_busy   = $urandom_range(1);
		lv.button_pressed = $urandom_range(1);
		if ($urandom_range(99) >= 8) begin
			case (seen_phase)
				PH_READY:   lv.host_data = ($urandom_range(3) != 0);
				PH_DONE:    lv.host_data = ($urandom_range(3) == 0);
				PH_READ:    lv.host_data = ($urandom_range(99) < ones_pct);
				PH_DISPLAY: lv.display_busy = ($urandom_range(2) == 0);
				default: ;
			endcase
			lv.button_pressed = 1'b0;
		end
		if (press_left != 0) begin
			press_left--;
			lv.button_pressed = 1'b1;
		end else if (may_press && seen_phase == PH_SLEEP && $urandom_range(99) < wake_pct) begin
			case ($urandom_range(3))
				0:       run = $urandom_range(4, 1);
				1:       run = (press_limit > 1) ? press_limit - 1 : 1;
				2:       run = press_limit;
				default: run = press_limit + $urandom_range(2);
			endcase
			press_left = run - 1;
			lv.button_pressed = 1'b1;
		end
	endtask

	// one random stretch; a press in progress is finished before it ends
	task automatic run_phase(input int unsigned count, input int unsigned idle_pct,
		input int unsigned busy_pct);
		wps_in_t     lv;
		int unsigned sent;
		send_idle_pct = idle_pct;
		stall_pct     = busy_pct;
		sent          = 0;
		while (sent < count || press_left != 0) begin
			shape_tick(sent < count, lv);
			send_tick(lv);
			sent++;
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// scripted wake cycle: no startup delay, one tick per count bit,
		// one tick per sleep period, no margin
		configure(16'd0, 8'd1, 16'd3, 24'd1, 8'd0);
		send_tick(levels(1'b0, 1'b0, 1'b0));         // startup over at once, power on
		send_tick(levels(1'b1, 1'b0, 1'b0));         // host ready
		send_tick(levels(1'b0, 1'b0, 1'b0));         // host done, clock toggles into read
		repeat (16) send_tick(levels(1'b1, 1'b0, 1'b0));   // all-ones sleep count
		send_tick(levels(1'b0, 1'b1, 1'b0));         // display still busy
		send_tick(levels(1'b1, 1'b0, 1'b0));         // display idle, power off, sleep
		send_tick(levels(1'b0, 1'b0, 1'b1));         // button press wakes the sleep
		send_tick(levels(1'b1, 1'b1, 1'b1));         // still held
		send_tick(levels(1'b0, 1'b0, 1'b0));         // short release: switch image
		send_tick(levels(1'b1, 1'b0, 1'b0));         // host ready, second mode bit low
		send_tick(levels(1'b0, 1'b1, 1'b1));         // host done: read is skipped
		@(negedge clk);
		in_valid <= 1'b0;

		// sender never idles; receiver holds off so the block backs up
		configure(16'd65535, 8'd2, 16'd4, 24'd3, 8'd1);
		ones_pct = 10;
		wake_pct = 10;
		@(posedge clk);
		hold_req = 1'b1;
		run_phase(100, 0, 0);

		// zero bit wait and zero sleep period act as one, largest margin
		configure(STARTUP_TICKS_RST, 8'd0, 16'd1, 24'd0, 8'd255);
		ones_pct = 50;
		run_phase(100, 51, 0);

		// longest bit wait
		configure(16'd1, 8'd255, 16'd2, 24'd2, 8'd0);
		ones_pct = 10;
		run_phase(120, 0, 51);

		// longest sleep period: only presses or a zero sleep count end the sleep
		configure(16'd0, 8'd3, 16'd40, 24'hFFFFFF, 8'd3);
		wake_pct = 20;
		run_phase(100, 28, 28);

		configure(STARTUP_TICKS_RST, 8'd1, 16'd6, 24'd1, DISPLAY_MARGIN_RST);
		wake_pct = 10;
		run_phase(100, 0, 0);

		// drain, then wait before the verdict
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		if (mismatches == 0)
			$display("wake_power_sequencer_test OK");
		else
			$display("wake_power_sequencer_test NOT OK");
		$finish;
	end

endmodule
